// ----- hw/rtl/arip_pkg.sv -----
// ----------------------------------------------------------------------------
// arip_pkg
// Shared types, constants and the character classifier for the radix parser.
// ----------------------------------------------------------------------------
package arip_pkg;

   // radix limits and digit mapping
   localparam logic [5:0] RadixMin  = 6'd2;
   localparam logic [5:0] RadixMax  = 6'd36;
   localparam logic [5:0] DigitTen  = 6'd10;
   localparam logic [5:0] NoDigit   = RadixMax;

   // character codes
   localparam logic [7:0] CharMinus = 8'h2D;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;
   localparam logic [7:0] CharLowA  = 8'h61;
   localparam logic [7:0] CharLowZ  = 8'h7A;
   localparam logic [7:0] CharUpA   = 8'h41;
   localparam logic [7:0] CharUpZ   = 8'h5A;

   // configuration register map
   localparam int unsigned CsrAddrWidth = 4;
   localparam int unsigned CsrDataWidth = 32;
   localparam logic [1:0]  RegRadix     = 2'd0;
   localparam logic [1:0]  RegSigned    = 2'd1;
   localparam logic [1:0]  RegWidth     = 2'd2;

   // register reset values
   localparam logic [5:0] RadixReset  = 6'd10;
   localparam logic       SignedReset = 1'b1;
   localparam logic [1:0] WidthReset  = 2'd2;

   // result width codes
   localparam logic [1:0] Width8  = 2'd0;
   localparam logic [1:0] Width16 = 2'd1;
   localparam logic [1:0] Width32 = 2'd2;
   localparam logic [1:0] Width64 = 2'd3;

   // queue depth between front and back
   localparam int unsigned QueueDepthDefault = 2;

   typedef struct packed {
      logic [5:0] radix;
      logic       signed_mode;
      logic [1:0] result_width;
   } cfg_type;

   // one classified character
   typedef struct packed {
      logic [5:0] digit;
      logic       digit_bad;
      logic       minus;
      logic       last;
   } ent_type;

   // map a character to 0..35, or NoDigit
   function automatic logic [5:0] digit_of(input logic [7:0] c);
      logic [7:0] d;
      begin
         d = {2'b00, NoDigit};
         if (c >= CharZero && c <= CharNine) begin
            d = c - CharZero;
         end else if (c >= CharLowA && c <= CharLowZ) begin
            d = c - CharLowA + {2'b00, DigitTen};
         end else if (c >= CharUpA && c <= CharUpZ) begin
            d = c - CharUpA + {2'b00, DigitTen};
         end
         return d[5:0];
      end
   endfunction

   // mask for the selected wrap width
   function automatic logic [63:0] width_mask(input logic [1:0] w);
      logic [63:0] m;
      begin
         unique case (w)
            Width8:  m = 64'h0000_0000_0000_00FF;
            Width16: m = 64'h0000_0000_0000_FFFF;
            Width32: m = 64'h0000_0000_FFFF_FFFF;
            default: m = 64'hFFFF_FFFF_FFFF_FFFF;
         endcase
         return m;
      end
   endfunction

endpackage

// ----- hw/rtl/arip_req_if.sv -----
// ----------------------------------------------------------------------------
// arip_req_if
// Character channel: one character of the number string per beat.
// ----------------------------------------------------------------------------
interface arip_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last_char;

   modport source (output valid, char_code, last_char, input ready);
   modport sink   (input valid, char_code, last_char, output ready);
endinterface

// ----- hw/rtl/arip_rsp_if.sv -----
// ----------------------------------------------------------------------------
// arip_rsp_if
// Result channel: parsed value and ok flag, one beat per string.
// ----------------------------------------------------------------------------
interface arip_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] value;
   logic        ok;

   modport source (output valid, value, ok, input ready);
   modport sink   (input valid, value, ok, output ready);
endinterface

// ----- hw/rtl/arip_csr.sv -----
// ----------------------------------------------------------------------------
// arip_csr
// APB-style register file holding radix, signed mode and result width.
// ----------------------------------------------------------------------------
module arip_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [arip_pkg::CsrAddrWidth-1:0]  paddr,
   input  logic [arip_pkg::CsrDataWidth-1:0]  pwdata,
   output logic [arip_pkg::CsrDataWidth-1:0]  prdata,
   output logic                               pready,
   output arip_pkg::cfg_type                  cfg
);
   import arip_pkg::*;

   logic [5:0] radix_ff, radix_in;
   logic       signed_ff, signed_in;
   logic [1:0] width_ff, width_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign wr_en   = psel && penable && pwrite && pready;

   // register write decode
   always_comb begin
      radix_in  = radix_ff;
      signed_in = signed_ff;
      width_in  = width_ff;
      if (wr_en) begin
         unique case (reg_idx)
            RegRadix:  radix_in  = pwdata[5:0];
            RegSigned: signed_in = pwdata[0];
            RegWidth:  width_in  = pwdata[1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff  <= RadixReset;
         signed_ff <= SignedReset;
         width_ff  <= WidthReset;
      end else begin
         radix_ff  <= radix_in;
         signed_ff <= signed_in;
         width_ff  <= width_in;
      end
   end

   // read mux
   always_comb begin
      unique case (reg_idx)
         RegRadix:  prdata = {{(CsrDataWidth-6){1'b0}}, radix_ff};
         RegSigned: prdata = {{(CsrDataWidth-1){1'b0}}, signed_ff};
         RegWidth:  prdata = {{(CsrDataWidth-2){1'b0}}, width_ff};
         default:   prdata = '0;
      endcase
   end

   assign cfg.radix        = radix_ff;
   assign cfg.signed_mode  = signed_ff;
   assign cfg.result_width = width_ff;

endmodule

// ----- hw/rtl/arip_front.sv -----
// ----------------------------------------------------------------------------
// arip_front
// Accepts character beats and classifies them into digit value and flags.
// ----------------------------------------------------------------------------
module arip_front (
   arip_req_if.sink          req_in,
   input  arip_pkg::cfg_type cfg,
   input  logic              q_full,
   output logic              q_push,
   output arip_pkg::ent_type q_data
);
   import arip_pkg::*;

   logic [5:0] digit;

   // take a beat whenever the queue has room
   assign req_in.ready = !q_full;
   assign q_push       = req_in.valid && !q_full;

   // classify the character
   assign digit            = digit_of(req_in.char_code);
   assign q_data.digit     = digit;
   assign q_data.digit_bad = (digit >= NoDigit) || (digit >= cfg.radix);
   assign q_data.minus     = (req_in.char_code == CharMinus);
   assign q_data.last      = req_in.last_char;

endmodule

// ----- hw/rtl/arip_queue.sv -----
// ----------------------------------------------------------------------------
// arip_queue
// Short register queue decoupling the classifier from the accumulator.
// ----------------------------------------------------------------------------
module arip_queue #(
   parameter int unsigned Depth = arip_pkg::QueueDepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  arip_pkg::ent_type wr_data,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output arip_pkg::ent_type rd_data
);
   import arip_pkg::*;

   localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);
   localparam logic [CntWidth-1:0] CntFull = CntWidth'(Depth);

   ent_type             mem_ff [Depth];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == CntFull);
   assign not_empty = (cnt_ff != '0);
   assign rd_data   = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

// ----- hw/rtl/arip_back.sv -----
// ----------------------------------------------------------------------------
// arip_back
// Multiply-add accumulator, string state and the result register.
// ----------------------------------------------------------------------------
module arip_back (
   input  logic              clock,
   input  logic              reset,
   input  arip_pkg::cfg_type cfg,
   input  logic              q_valid,
   input  arip_pkg::ent_type q_data,
   output logic              q_pop,
   arip_rsp_if.source        rsp_out
);
   import arip_pkg::*;

   // string state
   logic [63:0] acc_ff, acc_in;
   logic        neg_ff, neg_in;
   logic        err_ff, err_in;
   logic        first_ff, first_in;

   // result register, held raw and finished on the way out
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] res_acc_ff, res_acc_in;
   logic        res_neg_ff, res_neg_in;
   logic        res_err_ff, res_err_in;
   logic        res_sgn_ff, res_sgn_in;
   logic [1:0]  res_w_ff, res_w_in;

   logic [63:0] mask;
   logic [63:0] prod;
   logic [63:0] step_acc;
   logic        radix_ok;
   logic        take_minus;
   logic        rsp_free;
   logic [63:0] fin_mask;
   logic [63:0] fin_mag;
   logic [63:0] fin_val;

   assign mask     = width_mask(cfg.result_width);
   assign radix_ok = (cfg.radix >= RadixMin) && (cfg.radix <= RadixMax);
   assign prod     = acc_ff * {58'd0, cfg.radix};
   assign step_acc = (prod + {58'd0, q_data.digit}) & mask;

   // a last beat needs the result register free
   assign rsp_free = !rsp_valid_ff || rsp_out.ready;
   assign q_pop    = q_valid && (!q_data.last || rsp_free);

   assign take_minus = first_ff && cfg.signed_mode && q_data.minus;

   // per-character step
   always_comb begin
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      err_in       = err_ff;
      first_in     = first_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_out.ready;
      res_acc_in   = res_acc_ff;
      res_neg_in   = res_neg_ff;
      res_err_in   = res_err_ff;
      res_sgn_in   = res_sgn_ff;
      res_w_in     = res_w_ff;
      if (q_pop) begin
         if (take_minus) begin
            neg_in = 1'b1;
            if (q_data.last) begin
               err_in = 1'b1;
            end
         end else if (q_data.digit_bad) begin
            err_in = 1'b1;
         end else begin
            acc_in = step_acc;
         end
         first_in = 1'b0;
         if (!radix_ok) begin
            err_in = 1'b1;
         end
         if (q_data.last) begin
            rsp_valid_in = 1'b1;
            res_acc_in   = acc_in;
            res_neg_in   = neg_in;
            res_err_in   = err_in;
            res_sgn_in   = cfg.signed_mode;
            res_w_in     = cfg.result_width;
            acc_in       = '0;
            neg_in       = 1'b0;
            err_in       = 1'b0;
            first_in     = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         neg_ff       <= 1'b0;
         err_ff       <= 1'b0;
         first_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         neg_ff       <= neg_in;
         err_ff       <= err_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      res_acc_ff <= res_acc_in;
      res_neg_ff <= res_neg_in;
      res_err_ff <= res_err_in;
      res_sgn_ff <= res_sgn_in;
      res_w_ff   <= res_w_in;
   end

   // negate and sign-extend at the captured width
   assign fin_mask = width_mask(res_w_ff);
   assign fin_mag  = res_neg_ff ? ((64'd0 - res_acc_ff) & fin_mask) : res_acc_ff;

   always_comb begin
      unique case (res_w_ff)
         Width8:  fin_val = {{56{fin_mag[7] & res_sgn_ff}}, fin_mag[7:0]};
         Width16: fin_val = {{48{fin_mag[15] & res_sgn_ff}}, fin_mag[15:0]};
         Width32: fin_val = {{32{fin_mag[31] & res_sgn_ff}}, fin_mag[31:0]};
         default: fin_val = fin_mag;
      endcase
   end

   assign rsp_out.valid = rsp_valid_ff;
   assign rsp_out.value = res_err_ff ? 64'd0 : fin_val;
   assign rsp_out.ok    = !res_err_ff;

endmodule

// ----- hw/rtl/ascii_radix_integer_parser.sv -----
// A result beat is registered: the last character passes through the queue and then the result register.
// Throughput: one character per cycle while the queue has room; the accumulator's 64x6 multiply-add closes each step.
// A waiting result holds back only a last character; the queue then fills and stalls input.
// Reset (synchronous, active high): radix 10, signed mode on, 32-bit width, string restarted.
// ----------------------------------------------------------------------------
// ascii_radix_integer_parser
// Streams a number string in radix 2 to 36 and returns its integer value.
// ----------------------------------------------------------------------------
module ascii_radix_integer_parser #(
   parameter int unsigned QueueDepth = arip_pkg::QueueDepthDefault
) (
   input  logic                               clock,
   input  logic                               reset,
   arip_req_if.sink                           req_in,
   arip_rsp_if.source                         rsp_out,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [arip_pkg::CsrAddrWidth-1:0]  paddr,
   input  logic [arip_pkg::CsrDataWidth-1:0]  pwdata,
   output logic [arip_pkg::CsrDataWidth-1:0]  prdata,
   output logic                               pready
);
   import arip_pkg::*;

   cfg_type cfg;
   ent_type q_wr_data;
   ent_type q_rd_data;
   logic    q_push;
   logic    q_pop;
   logic    q_full;
   logic    q_not_empty;

   // configuration registers
   arip_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // character intake and classification
   arip_front u_front (
      .req_in (req_in),
      .cfg    (cfg),
      .q_full (q_full),
      .q_push (q_push),
      .q_data (q_wr_data)
   );

   // decoupling queue
   arip_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .wr_data   (q_wr_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .rd_data   (q_rd_data)
   );

   // accumulate and emit
   arip_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_valid (q_not_empty),
      .q_data  (q_rd_data),
      .q_pop   (q_pop),
      .rsp_out (rsp_out)
   );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams number strings into the radix parser under changing base, sign and
// width settings, with random idle and stall bursts on both channels. A
// predictor scores every result beat, and every register is read back after
// it is written.
// ----------------------------------------------------------------------------
module testbench;
   import arip_pkg::*;

   localparam int unsigned SettleCycles   = 4;
   localparam int unsigned LongHoldCycles = 300;
   localparam int unsigned LimitCycles    = 250000;
   localparam int unsigned PhaseChars     = 90;
   localparam int unsigned PhaseCount     = 14;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } char_beat_type;

   typedef struct packed {
      logic [63:0] value;
      logic        ok;
   } parse_result_type;

   logic clock;
   logic reset;

   // configuration port
   logic                    psel;
   logic                    penable;
   logic                    pwrite;
   logic [CsrAddrWidth-1:0] paddr;
   logic [CsrDataWidth-1:0] pwdata;
   logic [CsrDataWidth-1:0] prdata;
   logic                    pready;

   arip_req_if req_bus ();
   arip_rsp_if rsp_bus ();

   ascii_radix_integer_parser i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_in  (req_bus),
      .rsp_out (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // characters waiting to be sent, and parses waiting to come back
   char_beat_type    char_stream [$];
   parse_result_type pending_parses [$];

   // predictor copy of the registers and the string state
   cfg_type     parser_cfg;
   logic [63:0] acc_state;
   logic        minus_state;
   logic        error_state;
   logic        at_first_state;

   int unsigned chars_sent;
   int unsigned chars_taken;
   int unsigned results_seen;
   int unsigned settings_used;
   int unsigned error_count;
   int unsigned cycle_count;

   // handshake bookkeeping between the processes
   bit               req_beat_taken;
   bit               idle_on;
   bit               long_hold_req;
   int unsigned      send_gap;
   int unsigned      hold_left;
   char_beat_type    next_beat;
   parse_result_type want;

   // clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LimitCycles) begin
         $display("%0t: timeout, %0d results still outstanding", $time,
                  pending_parses.size());
         $display("Some tests failed");
         $finish;
      end
   end

   // wrap mask for a width code
   function automatic logic [63:0] wrap_mask(input logic [1:0] code);
      case (code)
         Width8:  return {56'd0, 8'hFF};
         Width16: return {48'd0, 16'hFFFF};
         Width32: return {32'd0, 32'hFFFF_FFFF};
         default: return '1;
      endcase
   endfunction

   // digit value of a character, RadixMax when it is no digit
   function automatic int unsigned char_value(input logic [7:0] c);
      int unsigned v;
      v = 32'(RadixMax);
      if (c >= CharZero && c <= CharNine) v = 32'(c - CharZero);
      if (c >= CharLowA && c <= CharLowZ) v = 32'(c - CharLowA + 8'(DigitTen));
      if (c >= CharUpA && c <= CharUpZ) v = 32'(c - CharUpA + 8'(DigitTen));
      return v;
   endfunction

   // character for a digit value, letters in random case
   function automatic logic [7:0] digit_char(input int unsigned d);
      if (d < DigitTen) return 8'(CharZero + d);
      if ($urandom_range(0, 1) == 0) return 8'(CharLowA + d - DigitTen);
      return 8'(CharUpA + d - DigitTen);
   endfunction

   function automatic void restart_string();
      acc_state      = '0;
      minus_state    = 1'b0;
      error_state    = 1'b0;
      at_first_state = 1'b1;
   endfunction

   // advance the predicted parse by one character
   task automatic predict_char(input logic [7:0] c, input logic last);
      logic [63:0]      mask;
      logic [63:0]      top;
      logic [63:0]      v;
      int unsigned      d;
      parse_result_type res;
      mask = wrap_mask(parser_cfg.result_width);
      if (at_first_state && parser_cfg.signed_mode && c == CharMinus) begin
         minus_state = 1'b1;
         if (last) error_state = 1'b1;
      end else begin
         d = char_value(c);
         if (d >= RadixMax || d >= parser_cfg.radix) begin
            error_state = 1'b1;
         end else begin
            acc_state = (acc_state * {58'd0, parser_cfg.radix} + 64'(d)) & mask;
         end
      end
      at_first_state = 1'b0;
      if (parser_cfg.radix < RadixMin || parser_cfg.radix > RadixMax) error_state = 1'b1;
      if (last) begin
         v = acc_state & mask;
         if (minus_state) v = (-v) & mask;
         // sign extension below 64 bits
         if (parser_cfg.signed_mode && parser_cfg.result_width != Width64) begin
            top = (mask >> 1) + 64'd1;
            if ((v & top) != 0) v = v | ~mask;
         end
         res.ok    = !error_state;
         res.value = res.ok ? v : '0;
         pending_parses.push_back(res);
         restart_string();
      end
   endtask

   // character channel driver
   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && !req_beat_taken) begin
         // beat still offered, hold it
      end else begin
         req_beat_taken = 1'b0;
         if (send_gap > 0) begin
            send_gap--;
            req_bus.valid <= 1'b0;
         end else if (char_stream.size() != 0 && idle_on && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(1, 12) - 1;
            req_bus.valid <= 1'b0;
         end else if (char_stream.size() != 0) begin
            next_beat = char_stream.pop_front();
            chars_sent++;
            req_bus.valid     <= 1'b1;
            req_bus.char_code <= next_beat.char_code;
            req_bus.last_char <= next_beat.last_char;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // character channel monitor
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         req_beat_taken = 1'b1;
         chars_taken++;
         predict_char(req_bus.char_code, req_bus.last_char);
      end
   end

   // result channel ready, with stall bursts and the long hold
   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (long_hold_req) begin
         long_hold_req = 1'b0;
         hold_left = LongHoldCycles - 1;
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         hold_left = $urandom_range(1, 12) - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (pending_parses.size() == 0) begin
            $display("%0t: result beat with none expected, value %h ok %b", $time,
                     rsp_bus.value, rsp_bus.ok);
            error_count++;
         end else begin
            want = pending_parses.pop_front();
            if (rsp_bus.value !== want.value) begin
               $display("%0t: value mismatch, expected %h actual %h", $time,
                        want.value, rsp_bus.value);
               error_count++;
            end
            if (rsp_bus.ok !== want.ok) begin
               $display("%0t: ok mismatch, expected %b actual %b", $time,
                        want.ok, rsp_bus.ok);
               error_count++;
            end
         end
      end
   end

   task automatic push_char(input logic [7:0] c, input logic last);
      char_beat_type b;
      b.char_code = c;
      b.last_char = last;
      char_stream.push_back(b);
   endtask

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
   endtask

   // register write followed by a read back
   task automatic csr_write(input logic [1:0] idx, input logic [5:0] field);
      logic [CsrDataWidth-1:0] keep;
      logic [CsrDataWidth-1:0] data;
      case (idx)
         RegRadix:  keep = 32'h3F;
         RegSigned: keep = 32'h1;
         default:   keep = 32'h3;
      endcase
      data = ($urandom() & ~keep) | ({26'd0, field} & keep);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (idx)
         RegRadix:  parser_cfg.radix        = data[5:0];
         RegSigned: parser_cfg.signed_mode  = data[0];
         default:   parser_cfg.result_width = data[1:0];
      endcase
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== (data & keep)) begin
         $display("%0t: register %0d read back, expected %h actual %h", $time, idx,
                  data & keep, prdata);
         error_count++;
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_config(input logic [5:0] radix, input logic sgn, input logic [1:0] w);
      csr_write(RegRadix, radix);
      csr_write(RegSigned, {5'd0, sgn});
      csr_write(RegWidth, {4'd0, w});
      settings_used++;
   endtask

   // sender pause until every character is in and every result is out
   task automatic wait_drained();
      while (char_stream.size() != 0 || chars_taken != chars_sent ||
             pending_parses.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   // one string: mostly well formed, some noise, lone minus or one bad char
   task automatic queue_random_string();
      int unsigned kind;
      int unsigned len;
      int unsigned span;
      int unsigned bad_at;
      logic [7:0]  c;
      kind = $urandom_range(0, 99);
      span = (parser_cfg.radix >= RadixMin && parser_cfg.radix <= RadixMax) ?
             32'(parser_cfg.radix) : 32'(RadixMax);
      len = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 24) : $urandom_range(1, 6);
      bad_at = (kind >= 90) ? $urandom_range(0, len - 1) : len;
      if (kind >= 85 && kind < 90) begin
         push_char(CharMinus, 1'b1);
         return;
      end
      if ($urandom_range(0, 2) == 0) push_char(CharMinus, 1'b0);
      for (int i = 0; i < len; i++) begin
         if (kind >= 75 && kind < 85) begin
            c = 8'($urandom_range(0, 255));
         end else if (i == bad_at) begin
            case ($urandom_range(0, 3))
               0: c = CharMinus;
               1: c = digit_char($urandom_range(span - 1, RadixMax - 1));
               2: c = 8'($urandom_range(0, 255));
               default: begin
                  case ($urandom_range(0, 5))
                     0: c = CharZero - 8'd1;
                     1: c = CharNine + 8'd1;
                     2: c = CharUpA - 8'd1;
                     3: c = CharUpZ + 8'd1;
                     4: c = CharLowA - 8'd1;
                     default: c = CharLowZ + 8'd1;
                  endcase
               end
            endcase
         end else begin
            c = digit_char($urandom_range(0, span - 1));
         end
         push_char(c, i == len - 1);
      end
   endtask

   // fixed settings for the random phases, extremes included
   logic [5:0] phase_radix  [10] = '{6'd10, 6'd2, 6'd36, 6'd16, 6'd8,
                                     6'd0, 6'd36, 6'd2, 6'd63, 6'd37};
   logic       phase_signed [10] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1,
                                     1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
   logic [1:0] phase_width  [10] = '{Width32, Width8, Width64, Width16, Width8,
                                     Width32, Width64, Width64, Width16, Width8};

   initial begin
      int unsigned queued;
      reset             = 1'b1;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      req_bus.valid     = 1'b0;
      req_bus.char_code = '0;
      req_bus.last_char = 1'b0;
      rsp_bus.ready     = 1'b0;
      parser_cfg        = '{radix: RadixReset, signed_mode: SignedReset,
                            result_width: WidthReset};
      restart_string();
      idle_on = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: minus handling, bad chars, digit too large
      queue_text("-9");
      push_char(CharMinus, 1'b1);
      queue_text("1-");
      push_char(8'h00, 1'b1);
      push_char(CharUpA, 1'b1);
      wait_drained();

      // base 36 unsigned 8 bit: wrap, minus refused, top char code
      set_config(6'd36, 1'b0, Width8);
      queue_text("zZ");
      queue_text("-1");
      push_char(8'hFF, 1'b1);
      wait_drained();

      // most negative 8 bit value stays put
      set_config(6'd16, 1'b1, Width8);
      queue_text("-80");
      queue_text("7f");
      wait_drained();

      // settings change in the middle of a string
      set_config(6'd10, 1'b1, Width32);
      push_char(CharZero + 8'd1, 1'b0);
      push_char(CharZero + 8'd2, 1'b0);
      wait_drained();
      set_config(6'd16, 1'b0, Width16);
      push_char(CharLowA + 8'd5, 1'b1);
      wait_drained();

      // base out of range
      set_config(6'd63, 1'b1, Width32);
      push_char(CharZero + 8'd1, 1'b1);
      wait_drained();

      // random phases, idle bursts off in the last three
      for (int p = 0; p < PhaseCount; p++) begin
         if (p < 10) begin
            set_config(phase_radix[p], phase_signed[p], phase_width[p]);
         end else if ($urandom_range(0, 3) != 0) begin
            set_config(6'($urandom_range(RadixMin, RadixMax)), 1'($urandom_range(0, 1)),
                       2'($urandom_range(0, 3)));
         end else begin
            set_config(6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)),
                       2'($urandom_range(0, 3)));
         end
         idle_on = (p < PhaseCount - 3);
         if (p == 2) long_hold_req = 1'b1;
         queued = 0;
         while (queued < PhaseChars) begin
            queued -= char_stream.size();
            queue_random_string();
            queued += char_stream.size();
         end
         wait_drained();
      end

      $display("%0d characters sent, %0d results checked, %0d register settings",
               chars_taken, results_seen, settings_used);
      $display("bases from 0 to 63, both sign modes, all four widths, long result stall");
      if (error_count == 0 && pending_parses.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
